// ----- src/mmcp_pkg.sv -----
// Shared types and constants for the min-max contiguous partition block.
`default_nettype none
package mmcp_pkg;
	localparam int OUT_W = 26;
	localparam int GC_W = 11;
	localparam logic [GC_W-1:0] GC_RESET = 11'd1;
	typedef logic [OUT_W-1:0] result_t;
	typedef logic [GC_W-1:0] group_cnt_t;
endpackage
`default_nettype wire

// ----- src/mmcp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module mmcp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- src/min_max_contiguous_partition.sv -----
// Top level: weight loader, binary search over the limit and greedy feasibility pass.
`default_nettype none
// Load a set with one start transaction per weight (busy stays low while loading);
// the transaction with last_item high starts the search and raises busy. The block
// binary-searches the limit over 0..total, about log2(total)+1 passes, and each
// pass streams the stored weights out of the weight RAM at one per cycle. A pass
// over n items runs through setup, the n reads, the read latency, the end check
// and the decision; a pass that fails early ends sooner. The result appears on
// min_max_sum for exactly one cycle with done high and cannot be held off; the
// receiver must take it then. group_count may be written only while busy is low.
// Items beyond MAX_ITEMS are dropped.
module min_max_contiguous_partition #(
	parameter int MAX_ITEMS = 1024,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [WEIGHT_BITS-1:0]   item_weight,
	input  wire logic                     last_item,
	input  wire logic                     group_count_we,
	input  wire logic [mmcp_pkg::GC_W-1:0] group_count,
	output logic                          done,
	output mmcp_pkg::result_t             min_max_sum
);
	import mmcp_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int SUM_W = WEIGHT_BITS + CNT_W;
	localparam int GRP_W = GC_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_MID,
		S_PASS,
		S_DECIDE
	} state_t;

	state_t               state_q;
	group_cnt_t           gc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     total_q;
	logic [SUM_W-1:0]     low_q;
	logic [SUM_W-1:0]     high_q;
	logic [SUM_W-1:0]     best_q;
	logic [SUM_W-1:0]     mid_q;
	logic [SUM_W-1:0]     acc_q;
	logic [GRP_W-1:0]     groups_q;
	logic [CNT_W-1:0]     ra_q;
	logic                 rd_vld_s1;
	logic                 fit_q;
	logic                 done_q;

	logic                 accept;
	logic                 wr_en;
	logic                 issue;
	logic [WEIGHT_BITS-1:0] rdata;
	logic [SUM_W-1:0]     w_ext;
	logic [SUM_W:0]       acc_sum;
	logic                 fits_add;
	logic [GRP_W-1:0]     groups_inc;
	logic                 item_fail;
	logic [SUM_W-1:0]     mid_dec;
	logic [SUM_W-1:0]     mid_inc;
	logic                 search_end;
	logic [SUM_W+OUT_W-1:0] best_ext;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign wr_en = accept && (cnt_q < CNT_W'(MAX_ITEMS));
	assign issue = (state_q == S_PASS) && (ra_q < cnt_q);

	mmcp_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(MAX_ITEMS)
	) u_weight_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(item_weight),
		.raddr(ra_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	// greedy step on the weight that arrives from the RAM
	assign w_ext = SUM_W'(rdata);
	assign acc_sum = {1'b0, acc_q} + {1'b0, w_ext};
	assign fits_add = (acc_sum <= {1'b0, mid_q});
	assign groups_inc = groups_q + GRP_W'(1);
	assign item_fail = (groups_inc > {1'b0, gc_q}) || (w_ext > mid_q);
	assign mid_dec = mid_q - SUM_W'(1);
	assign mid_inc = mid_q + SUM_W'(1);
	// search range exhausted after this decision
	assign search_end = fit_q ? ((mid_q == '0) || (mid_dec < low_q)) : (mid_inc > high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q <= GC_RESET;
		end else if (group_count_we) begin
			gc_q <= group_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			total_q   <= '0;
			low_q     <= '0;
			high_q    <= '0;
			best_q    <= '0;
			mid_q     <= '0;
			acc_q     <= '0;
			groups_q  <= '0;
			ra_q      <= '0;
			rd_vld_s1 <= 1'b0;
			fit_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_DECIDE) && search_end;
			rd_vld_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (wr_en) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							total_q <= total_q + SUM_W'(item_weight);
						end
						if (last_item) begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					low_q   <= '0;
					high_q  <= total_q;
					best_q  <= total_q;
					state_q <= S_MID;
				end
				S_MID: begin
					mid_q    <= low_q + ((high_q - low_q) >> 1);
					acc_q    <= '0;
					groups_q <= GRP_W'(1);
					ra_q     <= '0;
					fit_q    <= 1'b1;
					state_q  <= S_PASS;
				end
				S_PASS: begin
					if (issue) begin
						ra_q <= ra_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						if (fits_add) begin
							acc_q <= acc_sum[SUM_W-1:0];
						end else if (item_fail) begin
							// limit not feasible: abandon the pass, a read in flight is ignored
							fit_q   <= 1'b0;
							state_q <= S_DECIDE;
						end else begin
							groups_q <= groups_inc;
							acc_q    <= w_ext;
						end
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (fit_q) begin
						best_q <= mid_q;
						high_q <= mid_dec;
					end else begin
						low_q <= mid_inc;
					end
					if (search_end) begin
						cnt_q   <= '0;
						total_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MID;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign best_ext = {{OUT_W{1'b0}}, best_q};
	assign done = done_q;
	assign min_max_sum = best_ext[OUT_W-1:0];
endmodule
`default_nettype wire

// ----- src/mmcp_checker.sv -----
// Port-level checker for the min-max contiguous partition block, with its bind.
`default_nettype none
module mmcp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      last_item,
	input wire logic                      group_count_we,
	input wire logic                      done,
	input wire mmcp_pkg::result_t         min_max_sum
);
	// a closing transaction always starts a search
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_item |=> busy)
		else $error("search did not start after last item");

	// a non-closing transaction keeps the loader open and gives no result
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_item |=> !busy && !done)
		else $error("load transaction left the loader");

	// a result ends a search and carries a known value
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy && !$isunknown(min_max_sum))
		else $error("result without a search");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// group count only changes between searches
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		group_count_we |-> !busy)
		else $error("group count written during a search");
endmodule

bind min_max_contiguous_partition mmcp_checker u_mmcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.last_item     (last_item),
	.group_count_we(group_count_we),
	.done          (done),
	.min_max_sum   (min_max_sum)
);
`default_nettype wire
